/* design/edge_coverage_tracer_top_macros.svh */
// ----------------------------------------------------------------------------
// Edge coverage tracer assertion macros
// Shared concurrent assertion forms, clocked on clk_i, held off during reset.
// ----------------------------------------------------------------------------
`ifndef EDGE_COVERAGE_TRACER_TOP_MACROS_SVH
`define EDGE_COVERAGE_TRACER_TOP_MACROS_SVH

// same-cycle implication
`define ECT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ECT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/ect_pkg.sv */
// ----------------------------------------------------------------------------
// Edge coverage tracer package
// Request, result, configuration and internal command types plus op codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ect_pkg;

  localparam int PC_BITS       = 48;
  localparam int INDEX_BITS    = 16;
  localparam int MAP_ADDR_BITS = 20;

  localparam logic [2:0] OP_TRACE    = 3'd0;
  localparam logic [2:0] OP_RD_EDGE  = 3'd1;
  localparam logic [2:0] OP_RD_FULL  = 3'd2;
  localparam logic [2:0] OP_CLR_EDGE = 3'd3;
  localparam logic [2:0] OP_CLR_FULL = 3'd4;

  typedef struct packed {
    logic [2:0]            op;
    logic [PC_BITS-1:0]    pc;
    logic [INDEX_BITS-1:0] entry_index;
  } ect_req_t;

  typedef struct packed {
    logic [7:0] read_value;
    logic       range_error;
  } ect_rsp_t;

  typedef struct packed {
    logic               tracing_enabled;
    logic               full_map_enabled;
    logic [PC_BITS-1:0] text_base;
  } ect_cfg_t;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_TRACE,
    CMD_RD_EDGE,
    CMD_RD_FULL,
    CMD_CLR_EDGE,
    CMD_CLR_FULL
  } ect_kind_e;

  typedef struct packed {
    ect_kind_e                kind;
    logic                     edge_hit;
    logic [MAP_ADDR_BITS-1:0] edge_addr;
    logic                     full_hit;
    logic [MAP_ADDR_BITS-1:0] full_addr;
    logic [2:0]               full_bit;
    logic                     err;
  } ect_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } ect_qstat_t;

endpackage

`default_nettype wire

/* design/ect_ram.sv */
// ----------------------------------------------------------------------------
// Edge coverage tracer RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ect_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* design/ect_front.sv */
// ----------------------------------------------------------------------------
// Edge coverage tracer front end
// Classifies requests into map commands and tracks the previous location.
// ----------------------------------------------------------------------------
`default_nettype none

module ect_front #(
  parameter int EDGE_MAP_ENTRIES = 65536,
  parameter int FULL_MAP_BYTES   = 65536
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire ect_pkg::ect_req_t req_i,
  input  wire ect_pkg::ect_cfg_t cfg_i,
  output ect_pkg::ect_cmd_t      cmd_o
);

  import ect_pkg::*;

  localparam int EAW = $clog2(EDGE_MAP_ENTRIES);
  localparam int FAW = $clog2(FULL_MAP_BYTES);
  localparam logic [EAW-1:0]           EDGE_MASK = EAW'(EDGE_MAP_ENTRIES - 1);
  localparam logic [EAW:0]             EDGE_LIM  = (EAW + 1)'(EDGE_MAP_ENTRIES);
  localparam logic [PC_BITS-5:0]       FULL_LIM  = (PC_BITS - 4)'(FULL_MAP_BYTES);
  localparam logic [MAP_ADDR_BITS:0]   IX_EDGE   = (MAP_ADDR_BITS + 1)'(EDGE_MAP_ENTRIES);
  localparam logic [MAP_ADDR_BITS:0]   IX_FULL   = (MAP_ADDR_BITS + 1)'(FULL_MAP_BYTES);

  logic [EAW-1:0]           prev_q, prev_d;
  logic [EAW-1:0]           edge_idx;
  logic                     edge_hit;
  logic                     below_base;
  logic [PC_BITS-1:0]       diff;
  logic                     full_in;
  logic [MAP_ADDR_BITS:0]   ix_ext;
  ect_cmd_t                 cmd;

  assign edge_idx   = (req_i.pc[EAW:1] ^ prev_q) & EDGE_MASK;
  assign edge_hit   = {1'b0, edge_idx} < EDGE_LIM;
  assign below_base = req_i.pc < cfg_i.text_base;
  assign diff       = req_i.pc - cfg_i.text_base;
  assign full_in    = diff[PC_BITS-1:4] < FULL_LIM;
  assign ix_ext     = (MAP_ADDR_BITS + 1)'(req_i.entry_index);

  always_comb begin
    cmd    = '{kind: CMD_NOP, edge_hit: 1'b0, edge_addr: '0, full_hit: 1'b0,
               full_addr: '0, full_bit: 3'd0, err: 1'b0};
    prev_d = prev_q;
    case (req_i.op)
      OP_TRACE: begin
        if (cfg_i.tracing_enabled) begin
          cmd.kind      = CMD_TRACE;
          cmd.edge_hit  = edge_hit;
          cmd.edge_addr = MAP_ADDR_BITS'(edge_idx);
          prev_d        = req_i.pc[EAW+1:2] & EDGE_MASK;
          if (cfg_i.full_map_enabled) begin
            if (below_base || !full_in) begin
              cmd.err = 1'b1;
            end else begin
              cmd.full_hit  = 1'b1;
              cmd.full_addr = MAP_ADDR_BITS'(diff[FAW+3:4]);
              cmd.full_bit  = diff[3:1];
            end
          end
        end
      end
      OP_RD_EDGE: begin
        if (ix_ext < IX_EDGE) begin
          cmd.kind      = CMD_RD_EDGE;
          cmd.edge_addr = MAP_ADDR_BITS'(req_i.entry_index);
        end
      end
      OP_RD_FULL: begin
        if (ix_ext < IX_FULL) begin
          cmd.kind      = CMD_RD_FULL;
          cmd.full_addr = MAP_ADDR_BITS'(req_i.entry_index);
        end
      end
      OP_CLR_EDGE: begin
        cmd.kind = CMD_CLR_EDGE;
        prev_d   = '0;
      end
      OP_CLR_FULL: begin
        cmd.kind = CMD_CLR_FULL;
      end
      default: begin
        cmd.kind = CMD_NOP;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (push_i) begin
      prev_q <= prev_d;
    end
  end

  assign cmd_o = cmd;

endmodule

`default_nettype wire

/* design/ect_queue.sv */
// ----------------------------------------------------------------------------
// Edge coverage tracer command queue
// Two-entry FIFO between the front end and the map engine.
// ----------------------------------------------------------------------------
`default_nettype none

module ect_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire ect_pkg::ect_cmd_t cmd_i,
  input  wire logic              pop_i,
  output ect_pkg::ect_cmd_t      head_o,
  output ect_pkg::ect_qstat_t    stat_o
);

  import ect_pkg::*;

  ect_cmd_t   slot_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = ~wr_q;
    end
    if (pop_i) begin
      rd_d = ~rd_q;
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= cmd_i;
    end
  end

  assign head_o       = slot_q[rd_q];
  assign stat_o.empty = cnt_q == 2'd0;
  assign stat_o.full  = cnt_q == 2'd2;

endmodule

`default_nettype wire

/* design/ect_back.sv */
// ----------------------------------------------------------------------------
// Edge coverage tracer map engine
// Executes commands on the edge counter and full map RAMs; runs clear sweeps.
// ----------------------------------------------------------------------------
`default_nettype none
`include "edge_coverage_tracer_top_macros.svh"

module ect_back #(
  parameter int EDGE_MAP_ENTRIES = 65536,
  parameter int FULL_MAP_BYTES   = 65536
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ect_pkg::ect_cmd_t   head_i,
  input  wire ect_pkg::ect_qstat_t qstat_i,
  output logic                     pop_o,
  output logic                     init_busy_o,
  output logic                     done_o,
  output ect_pkg::ect_rsp_t        rsp_o
);

  import ect_pkg::*;

  localparam int EAW = $clog2(EDGE_MAP_ENTRIES);
  localparam int FAW = $clog2(FULL_MAP_BYTES);
  localparam int SW  = (EAW > FAW) ? EAW : FAW;
  localparam int MAX_ENTRIES =
    (EDGE_MAP_ENTRIES > FULL_MAP_BYTES) ? EDGE_MAP_ENTRIES : FULL_MAP_BYTES;
  localparam logic [SW-1:0] EDGE_LAST = SW'(EDGE_MAP_ENTRIES - 1);
  localparam logic [SW-1:0] FULL_LAST = SW'(FULL_MAP_BYTES - 1);
  localparam logic [SW-1:0] INIT_LAST = SW'(MAX_ENTRIES - 1);
  localparam logic [SW:0]   EDGE_LIM  = (SW + 1)'(EDGE_MAP_ENTRIES);
  localparam logic [SW:0]   FULL_LIM  = (SW + 1)'(FULL_MAP_BYTES);

  localparam logic [2:0] ST_INIT     = 3'd0;
  localparam logic [2:0] ST_IDLE     = 3'd1;
  localparam logic [2:0] ST_DATA     = 3'd2;
  localparam logic [2:0] ST_CLR_EDGE = 3'd3;
  localparam logic [2:0] ST_CLR_FULL = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [SW-1:0] cnt_q, cnt_d;
  ect_cmd_t      cmd_q, cmd_d;
  logic          done_q, done_d;
  ect_rsp_t      rsp_q, rsp_d;

  logic           e_we, e_re, f_we, f_re;
  logic [EAW-1:0] e_wa, e_ra;
  logic [FAW-1:0] f_wa, f_ra;
  logic [7:0]     e_wd, e_rd, f_wd, f_rd;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_d   = cmd_q;
    done_d  = 1'b0;
    rsp_d   = rsp_q;
    pop_o   = 1'b0;
    e_we    = 1'b0;
    e_wa    = cnt_q[EAW-1:0];
    e_wd    = 8'd0;
    e_re    = 1'b0;
    e_ra    = head_i.edge_addr[EAW-1:0];
    f_we    = 1'b0;
    f_wa    = cnt_q[FAW-1:0];
    f_wd    = 8'd0;
    f_re    = 1'b0;
    f_ra    = head_i.full_addr[FAW-1:0];
    case (state_q)
      ST_INIT: begin
        e_we  = {1'b0, cnt_q} < EDGE_LIM;
        f_we  = {1'b0, cnt_q} < FULL_LIM;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == INIT_LAST) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!qstat_i.empty) begin
          pop_o = 1'b1;
          cmd_d = head_i;
          e_re  = 1'b1;
          f_re  = 1'b1;
          cnt_d = '0;
          case (head_i.kind)
            CMD_TRACE, CMD_RD_EDGE, CMD_RD_FULL: state_d = ST_DATA;
            CMD_CLR_EDGE:                        state_d = ST_CLR_EDGE;
            CMD_CLR_FULL:                        state_d = ST_CLR_FULL;
            default: begin
              done_d = 1'b1;
              rsp_d  = '{read_value: 8'd0, range_error: head_i.err};
            end
          endcase
        end
      end
      ST_DATA: begin
        done_d            = 1'b1;
        rsp_d.range_error = cmd_q.err;
        case (cmd_q.kind)
          CMD_RD_EDGE: rsp_d.read_value = e_rd;
          CMD_RD_FULL: rsp_d.read_value = f_rd;
          default:     rsp_d.read_value = 8'd0;
        endcase
        if (cmd_q.kind == CMD_TRACE) begin
          e_we = cmd_q.edge_hit;
          e_wa = cmd_q.edge_addr[EAW-1:0];
          e_wd = e_rd + 8'd1;
          f_we = cmd_q.full_hit;
          f_wa = cmd_q.full_addr[FAW-1:0];
          f_wd = f_rd | (8'd1 << cmd_q.full_bit);
        end
        state_d = ST_IDLE;
      end
      ST_CLR_EDGE: begin
        e_we  = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == EDGE_LAST) begin
          done_d  = 1'b1;
          rsp_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_CLR_FULL: begin
        f_we  = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == FULL_LAST) begin
          done_d  = 1'b1;
          rsp_d   = '0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    rsp_q <= rsp_d;
  end

  ect_ram #(
    .WIDTH(8),
    .DEPTH(EDGE_MAP_ENTRIES)
  ) u_edge_ram (
    .clk_i  (clk_i),
    .we_i   (e_we),
    .waddr_i(e_wa),
    .wdata_i(e_wd),
    .re_i   (e_re),
    .raddr_i(e_ra),
    .rdata_o(e_rd)
  );

  ect_ram #(
    .WIDTH(8),
    .DEPTH(FULL_MAP_BYTES)
  ) u_full_ram (
    .clk_i  (clk_i),
    .we_i   (f_we),
    .waddr_i(f_wa),
    .wdata_i(f_wd),
    .re_i   (f_re),
    .raddr_i(f_ra),
    .rdata_o(f_rd)
  );

  assign init_busy_o = state_q == ST_INIT;
  assign done_o      = done_q;
  assign rsp_o       = rsp_q;

  `ECT_ASSERT_NXT(a_data_done, state_q == ST_DATA, done_q && (state_q == ST_IDLE), "access step did not finish")
  `ECT_ASSERT_NXT(a_clr_done, (state_q == ST_CLR_EDGE) && (cnt_q == EDGE_LAST), done_q && (state_q == ST_IDLE), "edge sweep did not finish")
  `ECT_ASSERT_IMP(a_no_init_result, done_q, $past(state_q) != ST_INIT, "result during init sweep")

endmodule

`default_nettype wire

/* design/edge_coverage_tracer_top.sv */
// ----------------------------------------------------------------------------
// Edge coverage tracer top: hashed-PC edge counters and full coverage bit map
// Trace/read, no-op requests (unknown op, tracing off, read past a map) and clears
// each end in a result strobe; busy is high while the command queue is full.
// Map engine: access step per trace/read, sweep per clear; 2-entry command queue.
// After reset, busy stays high while the init sweep clears the RAMs.
// ----------------------------------------------------------------------------
`default_nettype none

module edge_coverage_tracer_top #(
  parameter int EDGE_MAP_ENTRIES = 65536,
  parameter int FULL_MAP_BYTES   = 65536
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire ect_pkg::ect_req_t req_i,
  output logic                   result_valid_o,
  output ect_pkg::ect_rsp_t      rsp_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [4:0]        paddr,
  input  wire logic [63:0]       pwdata,
  output logic [63:0]            prdata,
  output logic                   pready
);

  import ect_pkg::*;

  localparam logic [1:0] REG_TRACE_EN = 2'd0;
  localparam logic [1:0] REG_FULL_EN  = 2'd1;
  localparam logic [1:0] REG_BASE     = 2'd2;

  ect_cfg_t   cfg_q;
  logic       cfg_we;
  logic       push;
  logic       pop;
  logic       init_busy;
  ect_cmd_t   cmd_in;
  ect_cmd_t   head;
  ect_qstat_t qstat;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we) begin
      case (paddr[4:3])
        REG_TRACE_EN: cfg_q.tracing_enabled  <= pwdata[0];
        REG_FULL_EN:  cfg_q.full_map_enabled <= pwdata[0];
        REG_BASE:     cfg_q.text_base        <= pwdata[PC_BITS-1:0];
        default:      cfg_q                  <= cfg_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      REG_TRACE_EN: prdata = {63'd0, cfg_q.tracing_enabled};
      REG_FULL_EN:  prdata = {63'd0, cfg_q.full_map_enabled};
      REG_BASE:     prdata = 64'(cfg_q.text_base);
      default:      prdata = 64'd0;
    endcase
  end

  assign busy = qstat.full || init_busy;
  assign push = start && !busy;

  ect_front #(
    .EDGE_MAP_ENTRIES(EDGE_MAP_ENTRIES),
    .FULL_MAP_BYTES  (FULL_MAP_BYTES)
  ) u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .req_i (req_i),
    .cfg_i (cfg_q),
    .cmd_o (cmd_in)
  );

  ect_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .cmd_i (cmd_in),
    .pop_i (pop),
    .head_o(head),
    .stat_o(qstat)
  );

  ect_back #(
    .EDGE_MAP_ENTRIES(EDGE_MAP_ENTRIES),
    .FULL_MAP_BYTES  (FULL_MAP_BYTES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .qstat_i    (qstat),
    .pop_o      (pop),
    .init_busy_o(init_busy),
    .done_o     (result_valid_o),
    .rsp_o      (rsp_o)
  );

endmodule

`default_nettype wire
